/* sv/lsh512_pkg.sv */
// lsh512_pkg: shared types, constants and helper functions for the LSH-512-512 engine.
// Depends on nothing; the controller, datapath and top level import it.

package lsh512_pkg;

    localparam int STEP_COUNT  = 28;
    localparam int BLOCK_WORDS = 32;
    localparam int CHAIN_WORDS = 16;

    // seed row of step constants; each later row is c + rotl(c, 8)
    localparam logic [63:0] STEP_SEED [8] = '{
        64'h97884283c938982a, 64'hba1fca93533e2355,
        64'hc519a2e87aeb1c03, 64'h9a0fc95462af17b1,
        64'hfc3dda8ab019a82b, 64'h02825d079a895407,
        64'h79f2d0a7ee06a6f7, 64'hd76d15eed9fdf5fe
    };

    localparam int GAMMA_ROT [8] = '{0, 16, 32, 48, 8, 24, 40, 56};
    localparam int EXPAND_SRC [16] = '{3, 2, 0, 1, 7, 4, 5, 6, 11, 10, 8, 9, 15, 12, 13, 14};
    localparam int PERM_SRC [16] = '{6, 4, 5, 7, 12, 15, 14, 13, 2, 0, 1, 3, 8, 11, 10, 9};

    localparam logic [63:0] PAD_WORD = 64'h80;

    // source of a block load into the expansion registers
    typedef enum logic [1:0] {
        SRC_BUF,
        SRC_PAD,
        SRC_ZERO
    } load_src_t;

    // controller to datapath commands
    typedef struct packed {
        logic      take;
        logic      load;
        load_src_t src;
        logic      step;
        logic      feed;
        logic      iv_save;
        logic      iv_load;
        logic [2:0] out_idx;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic pos_end;
    } dp_stat_t;

    // rotate left by a constant amount
    function automatic logic [63:0] rotl64(input logic [63:0] x, input int r);
        logic [63:0] res;
        if (r % 64 == 0)
            res = x;
        else
            res = (x << (r % 64)) | (x >> (64 - (r % 64)));
        return res;
    endfunction

endpackage

/* sv/lsh512_dp.sv */
// lsh512_dp: block buffer, message expansion, mix step and chaining value registers.
// Depends on lsh512_pkg; driven by lsh512_ctrl through dp_cmd_t.

module lsh512_dp
    import lsh512_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  dp_cmd_t     cmd,
    input  logic [63:0] message_word,
    input  logic [3:0]  valid_bytes,
    input  logic        last_word,
    output dp_stat_t    stat,
    output logic [63:0] digest_word
);

    logic [63:0] wbuf_reg  [BLOCK_WORDS];
    logic [4:0]  pos_reg;
    logic [4:0]  lim_reg;
    logic [63:0] chain_reg [CHAIN_WORDS];
    logic [63:0] iv_reg    [CHAIN_WORDS];
    logic [63:0] cur_reg   [CHAIN_WORDS];
    logic [63:0] nxt_reg   [CHAIN_WORDS];
    logic [63:0] sc_reg    [8];
    logic        odd_reg;

    logic [63:0] blk       [BLOCK_WORDS];
    logic [63:0] mixed     [CHAIN_WORDS];
    logic [63:0] fed       [CHAIN_WORDS];
    logic [63:0] exp_next  [CHAIN_WORDS];
    logic [63:0] sc_next   [8];
    logic [63:0] tail_word;
    logic [4:0]  pos_inc;
    logic        word_full;

    assign pos_inc      = pos_reg + 5'd1;
    assign word_full    = !last_word || valid_bytes[3];
    assign stat.pos_end = (pos_reg == 5'd31);

    // final partial word: keep bytes below the count, 0x80 at the count, zeros above
    always_comb
    begin
        for (int b = 0; b < 8; b++)
        begin
            if (4'(b) < valid_bytes)
                tail_word[8*b +: 8] = message_word[8*b +: 8];
            else if (4'(b) == valid_bytes)
                tail_word[8*b +: 8] = 8'h80;
            else
                tail_word[8*b +: 8] = 8'h00;
        end
    end

    // block selection for a load; words past the limit read as zero
    always_comb
    begin
        for (int i = 0; i < BLOCK_WORDS; i++)
        begin
            unique case (cmd.src)
                SRC_BUF:  blk[i] = (5'(i) <= lim_reg) ? wbuf_reg[i] : 64'd0;
                SRC_PAD:  blk[i] = (i == 0) ? PAD_WORD : 64'd0;
                SRC_ZERO: blk[i] = 64'd0;
                default:  blk[i] = 64'd0;
            endcase
        end
    end

    // eight-lane mix step and permutation; feed-forward, expansion, step constants
    always_comb
    begin
        logic [63:0] x   [8];
        logic [63:0] y   [8];
        logic [63:0] s1  [8];
        logic [63:0] x2  [8];
        logic [63:0] s2  [8];
        logic [63:0] y2  [8];
        logic [63:0] t   [16];
        for (int l = 0; l < 8; l++)
        begin
            x[l]  = chain_reg[l] ^ cur_reg[l];
            y[l]  = chain_reg[l+8] ^ cur_reg[l+8];
            s1[l] = x[l] + y[l];
            x2[l] = (odd_reg ? rotl64(s1[l], 7) : rotl64(s1[l], 23)) ^ sc_reg[l];
            s2[l] = x2[l] + y[l];
            y2[l] = odd_reg ? rotl64(s2[l], 3) : rotl64(s2[l], 59);
            t[l]   = x2[l] + y2[l];
            t[l+8] = rotl64(y2[l], GAMMA_ROT[l]);
        end
        for (int l = 0; l < CHAIN_WORDS; l++)
        begin
            mixed[l]    = t[PERM_SRC[l]];
            fed[l]      = chain_reg[l] ^ cur_reg[l];
            exp_next[l] = nxt_reg[l] + cur_reg[EXPAND_SRC[l]];
        end
        for (int l = 0; l < 8; l++)
            sc_next[l] = sc_reg[l] + rotl64(sc_reg[l], 8);
    end

    // chaining value and word position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int l = 0; l < CHAIN_WORDS; l++)
                chain_reg[l] <= 64'd0;
            chain_reg[0] <= 64'd64;
            chain_reg[1] <= 64'd512;
            pos_reg      <= 5'd0;
        end
        else
        begin
            if (cmd.step)
                chain_reg <= mixed;
            else if (cmd.feed)
                chain_reg <= fed;
            else if (cmd.iv_load)
                chain_reg <= iv_reg;

            if (cmd.iv_load)
                pos_reg <= 5'd0;
            else if (cmd.take)
                pos_reg <= pos_inc;
        end
    end

    // block buffer, expansion registers, step constants, IV store
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            if (word_full)
            begin
                wbuf_reg[pos_reg] <= message_word;
                if (last_word && !stat.pos_end)
                begin
                    wbuf_reg[pos_inc] <= PAD_WORD;
                    lim_reg           <= pos_inc;
                end
                else
                    lim_reg <= 5'd31;
            end
            else
            begin
                wbuf_reg[pos_reg] <= tail_word;
                lim_reg           <= pos_reg;
            end
        end

        if (cmd.load)
        begin
            for (int l = 0; l < CHAIN_WORDS; l++)
            begin
                cur_reg[l] <= blk[l];
                nxt_reg[l] <= blk[l+16];
            end
            sc_reg  <= STEP_SEED;
            odd_reg <= 1'b0;
        end
        else if (cmd.step)
        begin
            cur_reg <= nxt_reg;
            nxt_reg <= exp_next;
            sc_reg  <= sc_next;
            odd_reg <= !odd_reg;
        end

        if (cmd.iv_save)
            iv_reg <= fed;
    end

    // digest word: chain low half XOR high half
    assign digest_word = chain_reg[{1'b0, cmd.out_idx}] ^ chain_reg[{1'b1, cmd.out_idx}];

endmodule

/* sv/lsh512_ctrl.sv */
// lsh512_ctrl: sequencer for word intake, compression steps, padding and digest output.
// Depends on lsh512_pkg; commands lsh512_dp through dp_cmd_t.

module lsh512_ctrl
    import lsh512_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  logic [3:0] valid_bytes,
    input  logic     last_word,
    output logic     out_valid,
    input  logic     out_stall,
    output logic     digest_last,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_LOAD,
        S_STEP,
        S_FEED,
        S_IDLE,
        S_OUT
    } state_t;

    state_t     state_reg, state_next;
    logic [4:0] stepc_reg, stepc_next;
    load_src_t  src_reg, src_next;
    logic       init_reg, init_next;
    logic       pend_reg, pend_next;
    logic       fin_reg, fin_next;
    logic [2:0] k_reg, k_next;
    logic       in_take;
    logic       out_take;

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = (state_reg == S_OUT);
    assign digest_last = out_valid && (k_reg == 3'd7);
    assign in_take     = in_valid && !in_stall;
    assign out_take    = out_valid && !out_stall;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        stepc_next = stepc_reg;
        src_next   = src_reg;
        init_next  = init_reg;
        pend_next  = pend_reg;
        fin_next   = fin_reg;
        k_next     = k_reg;

        cmd         = '0;
        cmd.src     = src_reg;
        cmd.take    = in_take;
        cmd.out_idx = k_reg;

        unique case (state_reg)
            S_LOAD:
            begin
                cmd.load   = 1'b1;
                stepc_next = 5'd0;
                state_next = S_STEP;
            end
            S_STEP:
            begin
                cmd.step   = 1'b1;
                stepc_next = stepc_reg + 5'd1;
                if (stepc_reg == 5'(STEP_COUNT - 1))
                    state_next = S_FEED;
            end
            S_FEED:
            begin
                cmd.feed = 1'b1;
                if (init_reg)
                begin
                    cmd.iv_save = 1'b1;
                    init_next   = 1'b0;
                    state_next  = S_IDLE;
                end
                else if (pend_reg)
                begin
                    pend_next  = 1'b0;
                    fin_next   = 1'b1;
                    src_next   = SRC_PAD;
                    state_next = S_LOAD;
                end
                else if (fin_reg)
                begin
                    k_next     = 3'd0;
                    state_next = S_OUT;
                end
                else
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_take)
                begin
                    src_next = SRC_BUF;
                    if (!last_word)
                    begin
                        if (stat.pos_end)
                        begin
                            fin_next   = 1'b0;
                            state_next = S_LOAD;
                        end
                    end
                    else if (valid_bytes[3] && stat.pos_end)
                    begin
                        // block filled exactly: padding block follows
                        pend_next  = 1'b1;
                        fin_next   = 1'b0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        fin_next   = 1'b1;
                        state_next = S_LOAD;
                    end
                end
            end
            S_OUT:
            begin
                if (out_take)
                begin
                    if (k_reg == 3'd7)
                    begin
                        cmd.iv_load = 1'b1;
                        fin_next    = 1'b0;
                        state_next  = S_IDLE;
                    end
                    else
                        k_next = k_reg + 3'd1;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // state and control registers; reset runs the IV pass first
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            stepc_reg <= 5'd0;
            src_reg   <= SRC_ZERO;
            init_reg  <= 1'b1;
            pend_reg  <= 1'b0;
            fin_reg   <= 1'b0;
            k_reg     <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            stepc_reg <= stepc_next;
            src_reg   <= src_next;
            init_reg  <= init_next;
            pend_reg  <= pend_next;
            fin_reg   <= fin_next;
            k_reg     <= k_next;
        end
    end

endmodule

/* sv/lsh512_hash_engine_unit.sv */
// LSH-512-512 hash engine: 64-bit little-endian message words in, eight digest words out.
// A word that does not close a block is only stored; a block is compressed by a load, 28 mix
// steps on the single step unit and feed-forward, input stalled; a closing word adds one more
// block when the message fills a block exactly, then 8 digest words are offered.
// After reset the engine derives the IV by one compression before taking a word.
// Depends on lsh512_pkg, lsh512_ctrl and lsh512_dp.

module lsh512_hash_engine_unit
    import lsh512_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] message_word,
    input  logic [3:0]  valid_bytes,
    input  logic        last_word,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] digest_word,
    output logic        digest_last
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    lsh512_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .valid_bytes (valid_bytes),
        .last_word   (last_word),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .digest_last (digest_last),
        .stat        (stat),
        .cmd         (cmd)
    );

    lsh512_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .message_word (message_word),
        .valid_bytes  (valid_bytes),
        .last_word    (last_word),
        .stat         (stat),
        .digest_word  (digest_word)
    );

    // no word taken while digest words are on offer
    assert property (@(posedge clk) disable iff (!rst_n) !(out_valid && !in_stall))
        else $error("input open during digest output");

    // last digest flag only with a valid digest word
    assert property (@(posedge clk) disable iff (!rst_n) digest_last |-> out_valid)
        else $error("digest_last without out_valid");

    // after the final digest word the engine is ready for a new message
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && digest_last) |=> (!in_stall && !out_valid))
        else $error("engine not idle after digest");

endmodule
